@@ src/s2d_pkg.sv @@
// Shared types and constants for the signed 16-bit to decimal ASCII converter.
// No dependencies; s2d_cell and the top level import this package.
package s2d_pkg;

    localparam int MAG_W      = 16;
    localparam int NUM_DIGITS = 5;
    localparam int STEP_W     = $clog2(MAG_W);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [3:0] RADIX      = 4'd10;

    typedef logic [3:0] digit_t;

    // Control that the sequencer broadcasts to every digit cell.
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_DIGIT
    } state_t;

endpackage

@@ src/s2d_in_if.sv @@
// Input channel: one signed 16-bit integer per item with valid/ready.
// Depends on nothing.
interface s2d_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ src/s2d_out_if.sv @@
// Output channel: one ASCII character per item plus an end-of-number flag.
// Depends on nothing.
interface s2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ src/s2d_cell.sv @@
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on s2d_pkg.
module s2d_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  s2d_pkg::cell_ctrl_t ctrl,
    input  logic              shift_in,
    output logic              carry_out,
    output s2d_pkg::digit_t   digit
);
    import s2d_pkg::*;

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    // A digit of five or more would pass nine after doubling, so it is
    // corrected by three first; its top bit then moves to the next cell.
    always_comb
    begin
        adj        = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        carry_out  = adj[3];
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.shift)
        begin
            digit_next = {adj[2:0], shift_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

@@ src/signed_int16_to_decimal_ascii_unit.sv @@
// Signed 16-bit integer to decimal ASCII text converter, top level.
// Depends on s2d_pkg, s2d_in_if, s2d_out_if and s2d_cell.
//
// Usage:
//   num  (sink)  : one signed 16-bit value per item.
//   text (source): the value's decimal text, one ASCII character per item,
//                  most significant digit first, '-' ahead of a negative
//                  value, no leading zeros, last_char high on the final one.
//   A value is taken only while the unit is idle. Its magnitude is shifted
//   through a row of five BCD digit cells in 16 shift steps, one bit per
//   cycle, then a scan state finds the leading digit. The characters are
//   then presented, one per cycle while text.ready is high. The next value
//   is accepted in the cycle after the last character enters the output
//   register. When the receiver stalls, the character in the output
//   register holds and the unit waits. Reset empties the output register,
//   clears the cells and returns the unit to idle.
module signed_int16_to_decimal_ascii_unit (
    input  logic clk,
    input  logic rst_n,
    s2d_in_if.sink    num,
    s2d_out_if.source text
);
    import s2d_pkg::*;

    state_t state_reg, state_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;

    cell_ctrl_t ctrl;
    digit_t     digits [NUM_DIGITS];
    logic       carry  [NUM_DIGITS];
    logic       out_load;
    logic [IDX_W-1:0] top_idx;
    digit_t     digit_sel;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                s2d_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .shift_in  (mag_reg[MAG_W-1]),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
            else
            begin : g_rest
                s2d_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .shift_in  (carry[gi-1]),
                    .carry_out (carry[gi]),
                    .digit     (digits[gi])
                );
            end
        end
    endgenerate

    // Highest nonzero digit; zero leaves the index at the units digit.
    always_comb
    begin
        top_idx = '0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (digits[i] != '0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign digit_sel = digits[idx_reg];
    assign out_load  = !out_valid_reg || text.ready;
    assign num.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !text.ready;
        ctrl.clear     = 1'b0;
        ctrl.shift     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (num.valid)
                begin
                    neg_next   = num.value[MAG_W-1];
                    // The 16-bit negate of the most negative value is its
                    // correct unsigned magnitude.
                    mag_next   = num.value[MAG_W-1] ? MAG_W'(-num.value)
                                                    : MAG_W'(num.value);
                    step_next  = '0;
                    ctrl.clear = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.shift = 1'b1;
                mag_next   = {mag_reg[MAG_W-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_W'(MAG_W - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next   = top_idx;
                state_next = neg_reg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_ZERO + {4'b0000, digit_sel};
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.char_code = char_reg;
    assign text.last_char = last_reg;

    // The step counter only runs during conversion.
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CONV) |-> (step_reg == '0 || $past(state_reg) == ST_CONV))
        else $error("step counter left running outside conversion");

    // Conversion always finishes with all sixteen bits shifted out.
    a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (mag_reg == '0))
        else $error("magnitude bits left after conversion");

    // Every emitted digit is a valid decimal digit.
    a_bcd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIGIT) |-> (digit_sel < RADIX))
        else $error("digit cell holds a non-decimal value");

    // The minus sign is never flagged as the final character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && char_reg == CHAR_MINUS) |-> !last_reg)
        else $error("minus sign flagged as last character");

    // An accepted value starts a conversion with the step counter at zero.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (num.valid && num.ready) |=> (state_reg == ST_CONV && step_reg == '0))
        else $error("accepted value did not start a conversion");

endmodule
